// ----- hw/rtl/afc_pkg.sv -----
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants for the box versus frustum plane cull test.
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int PLANE_MAX  = 6;   // clip plane registers
	localparam int REG_W      = 64;  // configuration data width
	localparam int ADDR_W     = 6;   // byte address, 8 bytes per register
	localparam int N_BITS     = 12;  // normal component, Q1.10
	localparam int D_BITS     = 28;  // plane offset, 8 fraction bits
	localparam int D_LSB      = 36;
	localparam int SLACK_BITS = 16;
	localparam int FRAC_SHIFT = 10;  // aligns d and slack with the products

	localparam logic [2:0]            REG_SLACK   = 3'd6;
	localparam logic [SLACK_BITS-1:0] SLACK_RESET = 16'd1;

	// control fields that ride along with a box through the cell row
	typedef struct packed {
		logic                 empty;
		logic                 culled;
		logic [PLANE_MAX-1:0] mask;
	} afc_ctl_t;

	// register write into one cell
	typedef struct packed {
		logic             en;
		logic [REG_W-1:0] data;
	} afc_wr_t;

endpackage

// ----- hw/rtl/aabb_frustum_cull_test_unit.sv -----
// ----------------------------------------------------------------------------
// Path from input transaction to out_valid: two register stages per plane
// cell plus the output register.
// Throughput: one box per cycle; a stalled output holds the row, bubbles close.
// Reset: clears all valid flags, plane registers to zero, slack to one.
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit
// Tests one axis-aligned box against up to six clip planes and reports
// whether it may be visible. One cell per plane in a pipelined row.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_unit import afc_pkg::*; #(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ADDR_W-1:0]            paddr,
	input  logic [REG_W-1:0]             pwdata,
	output logic [REG_W-1:0]             prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] min_x,
	input  logic signed [COORD_BITS-1:0] min_y,
	input  logic signed [COORD_BITS-1:0] min_z,
	input  logic signed [COORD_BITS-1:0] max_x,
	input  logic signed [COORD_BITS-1:0] max_y,
	input  logic signed [COORD_BITS-1:0] max_z,
	input  logic [PLANE_MAX-1:0]         plane_mask,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         visible
);

	logic [2:0]            reg_idx;
	logic                  cfg_wr;
	logic [SLACK_BITS-1:0] slack_q;
	logic [REG_W-1:0]      rd_plane [PLANE_MAX];

	logic                       vld_c [PLANE_COUNT+1];
	logic                       rdy_c [PLANE_COUNT+1];
	afc_ctl_t                   ctl_c [PLANE_COUNT+1];
	logic [2:0][COORD_BITS-1:0] lo_c  [PLANE_COUNT+1];
	logic [2:0][COORD_BITS-1:0] hi_c  [PLANE_COUNT+1];

	logic out_valid_q, visible_q;

	// configuration
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slack_q <= SLACK_RESET;
		end else if (cfg_wr && reg_idx == REG_SLACK) begin
			slack_q <= pwdata[SLACK_BITS-1:0];
		end
	end

	always_comb begin
		if (reg_idx < 3'(PLANE_MAX)) begin
			prdata = rd_plane[reg_idx];
		end else if (reg_idx == REG_SLACK) begin
			prdata = REG_W'(slack_q);
		end else begin
			prdata = '0;
		end
	end

	// row entry
	assign vld_c[0]        = in_valid;
	assign ctl_c[0].empty  = (min_x > max_x) || (min_y > max_y) || (min_z > max_z);
	assign ctl_c[0].culled = 1'b0;
	assign ctl_c[0].mask   = plane_mask;
	assign lo_c[0]         = {min_z, min_y, min_x};
	assign hi_c[0]         = {max_z, max_y, max_x};
	assign in_stall        = !rdy_c[0];

	for (genvar i = 0; i < PLANE_MAX; i++) begin : g_plane
		if (i < PLANE_COUNT) begin : g_cell
			afc_wr_t wr;
			assign wr.en   = cfg_wr && (reg_idx == 3'(i));
			assign wr.data = pwdata;

			afc_cell #(
				.COORD_BITS (COORD_BITS),
				.IDX        (i)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr      (wr),
				.slack   (slack_q),
				.plane   (rd_plane[i]),
				.vld_in  (vld_c[i]),
				.ctl_in  (ctl_c[i]),
				.lo_in   (lo_c[i]),
				.hi_in   (hi_c[i]),
				.rdy_out (rdy_c[i]),
				.vld_out (vld_c[i+1]),
				.ctl_out (ctl_c[i+1]),
				.lo_out  (lo_c[i+1]),
				.hi_out  (hi_c[i+1]),
				.rdy_in  (rdy_c[i+1])
			);
		end else begin : g_none
			assign rd_plane[i] = '0;
		end
	end

	// output register
	assign rdy_c[PLANE_COUNT] = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_c[PLANE_COUNT]) begin
			out_valid_q <= vld_c[PLANE_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_c[PLANE_COUNT] && vld_c[PLANE_COUNT]) begin
			visible_q <= ctl_c[PLANE_COUNT].empty || !ctl_c[PLANE_COUNT].culled;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = visible_q;

`ifndef SYNTHESIS
	// input only backs up when the whole row is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output free");

	// a box leaving the last cell reaches the output register
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_c[PLANE_COUNT] && (!out_valid || !out_stall)) |=> out_valid)
		else $error("result lost at output register");

	// slack register only moves on a configuration write
	a_slack: assert property (@(posedge clk) disable iff (!arst_n)
		!(psel && penable && pwrite) |=> $stable(slack_q))
		else $error("slack changed without a write");
`endif

endmodule

// ----- hw/rtl/afc_cell.sv -----
// ----------------------------------------------------------------------------
// afc_cell
// One plane of the cull row: holds its plane register, forms the plane
// distance of the box corner in two stages and hands the box to the next cell.
// ----------------------------------------------------------------------------
module afc_cell import afc_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int IDX        = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  afc_wr_t                    wr,
	input  logic [SLACK_BITS-1:0]      slack,
	output logic [REG_W-1:0]           plane,
	input  logic                       vld_in,
	input  afc_ctl_t                   ctl_in,
	input  logic [2:0][COORD_BITS-1:0] lo_in,
	input  logic [2:0][COORD_BITS-1:0] hi_in,
	output logic                       rdy_out,
	output logic                       vld_out,
	output afc_ctl_t                   ctl_out,
	output logic [2:0][COORD_BITS-1:0] lo_out,
	output logic [2:0][COORD_BITS-1:0] hi_out,
	input  logic                       rdy_in
);

	localparam int PW    = COORD_BITS + N_BITS;
	localparam int SUM_A = COORD_BITS + 14;
	localparam int SUM_B = D_BITS + FRAC_SHIFT + 1;
	localparam int SUM_W = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 1;

	logic [REG_W-1:0] plane_q;

	logic                       v_s1, v_s2;
	logic                       rdy_s1, rdy_s2;
	afc_ctl_t                   ctl_s1, ctl_s2, ctl_nxt;
	logic [2:0][COORD_BITS-1:0] lo_s1, hi_s1, lo_s2, hi_s2;
	logic signed [PW-1:0]       prod_d  [3];
	logic signed [PW-1:0]       prod_s1 [3];
	logic signed [SUM_W-1:0]    d_term, s_term, sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (wr.en) begin
			plane_q <= wr.data;
		end
	end

	assign plane = plane_q;

	// n.(lo+hi) + |n|.(hi-lo) reduces to 2n.hi for n >= 0 and 2n.lo otherwise
	for (genvar a = 0; a < 3; a++) begin : g_axis
		logic [COORD_BITS-1:0] sel;
		assign sel = plane_q[N_BITS*a + N_BITS-1] ? lo_in[a] : hi_in[a];
		assign prod_d[a] = $signed(plane_q[N_BITS*a +: N_BITS]) * $signed(sel);
	end

	assign rdy_s2  = !v_s2 || rdy_in;
	assign rdy_s1  = !v_s1 || rdy_s2;
	assign rdy_out = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= vld_in;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && vld_in) begin
			ctl_s1 <= ctl_in;
			lo_s1  <= lo_in;
			hi_s1  <= hi_in;
			for (int a = 0; a < 3; a++) begin
				prod_s1[a] <= prod_d[a];
			end
		end
	end

	// culled when sum(n.c) + d + slack falls below zero, all in 18 fraction bits
	assign d_term = SUM_W'($signed(plane_q[D_LSB +: D_BITS])) <<< FRAC_SHIFT;
	assign s_term = $signed(SUM_W'({slack, {FRAC_SHIFT{1'b0}}}));
	assign sum    = SUM_W'(prod_s1[0]) + SUM_W'(prod_s1[1]) + SUM_W'(prod_s1[2])
	              + d_term + s_term;

	always_comb begin
		ctl_nxt        = ctl_s1;
		ctl_nxt.culled = ctl_s1.culled | (ctl_s1.mask[IDX] & sum[SUM_W-1]);
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			ctl_s2 <= ctl_nxt;
			lo_s2  <= lo_s1;
			hi_s2  <= hi_s1;
		end
	end

	assign vld_out = v_s2;
	assign ctl_out = ctl_s2;
	assign lo_out  = lo_s2;
	assign hi_out  = hi_s2;

endmodule
